[rtl/tpe_pkg.sv]
// Shared types, widths and helper functions for the TMDS pixel encoder.
package tpe_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SYM_W  = 10;
  localparam int unsigned PAIR_W = 2 * SYM_W;
  localparam int unsigned DISP_W = 5;

  typedef logic [BYTE_W-1:0]        byte_t;
  typedef logic [SYM_W-1:0]         symbol_t;
  typedef logic [PAIR_W-1:0]        pairs_t;
  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [3:0]               count_t;

  function automatic count_t popcount8(input byte_t value);
    count_t n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + count_t'(value[i]);
    end
    return n;
  endfunction

  function automatic pairs_t spread_pairs(input symbol_t sym);
    pairs_t p;
    p = '0;
    for (int i = 0; i < SYM_W; i++) begin
      p[2*i]   = sym[i];
      p[2*i+1] = ~sym[i];
    end
    return p;
  endfunction

  function automatic symbol_t positive_bits(input pairs_t p);
    symbol_t s;
    s = '0;
    for (int i = 0; i < SYM_W; i++) begin
      s[i] = p[2*i];
    end
    return s;
  endfunction

  function automatic symbol_t negative_bits(input pairs_t p);
    symbol_t s;
    s = '0;
    for (int i = 0; i < SYM_W; i++) begin
      s[i] = p[2*i+1];
    end
    return s;
  endfunction

endpackage

[rtl/tmds_pixel_encoder.sv]
// TMDS pixel encoder: DVI data symbol encoding with running disparity.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid / in_ready   | pixel_byte
//   out     | output    | out_valid / out_ready | tmds_symbol, pair_bits, new_disparity
//
// One transaction per cycle is sustained while out_ready is high. A byte is held in
// an input register, encoded by combinational logic and written to the output
// register, which presents the result. The output register also holds the
// running disparity, which rst clears to zero. When out_ready is low both
// registers fill and in_ready drops until the output transaction completes.
module tmds_pixel_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tpe_pkg::byte_t              pixel_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tpe_pkg::symbol_t            tmds_symbol,
  output tpe_pkg::pairs_t             pair_bits,
  output logic signed [tpe_pkg::DISP_W-1:0] new_disparity
);

  logic             hold_valid;
  tpe_pkg::byte_t   hold_byte;
  logic             advance;

  tpe_pkg::count_t  ones_in;
  logic             use_xnor;
  tpe_pkg::byte_t   chain;
  tpe_pkg::count_t  ones_chain;
  logic             flag8;
  logic             disp_pos;
  logic             disp_zero;
  logic             chain_more_ones;
  logic signed [5:0] excess;
  logic signed [5:0] delta;
  tpe_pkg::symbol_t symbol_next;
  tpe_pkg::disp_t   disparity_next;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_byte <= pixel_byte;
    end
  end

  always_comb begin
    ones_in  = tpe_pkg::popcount8(hold_byte);
    use_xnor = (ones_in > 4'd4) || (ones_in == 4'd4 && !hold_byte[0]);
    chain[0] = hold_byte[0];
    for (int i = 1; i < tpe_pkg::BYTE_W; i++) begin
      chain[i] = hold_byte[i] ^ chain[i-1] ^ use_xnor;
    end
    flag8      = !use_xnor;
    ones_chain = tpe_pkg::popcount8(chain);
    excess     = $signed({1'b0, ones_chain, 1'b0}) - 6'sd8;

    disp_zero       = (new_disparity == '0);
    disp_pos        = !new_disparity[tpe_pkg::DISP_W-1] && !disp_zero;
    chain_more_ones = ones_chain > 4'd4;

    if (disp_zero || ones_chain == 4'd4) begin
      if (flag8) begin
        symbol_next = {2'b01, chain};
        delta       = excess;
      end else begin
        symbol_next = {2'b10, ~chain};
        delta       = -excess;
      end
    end else if ((disp_pos && chain_more_ones) ||
                 (!disp_pos && ones_chain < 4'd4)) begin
      symbol_next = {1'b1, flag8, ~chain};
      delta       = (flag8 ? 6'sd2 : 6'sd0) - excess;
    end else begin
      symbol_next = {1'b0, flag8, chain};
      delta       = excess - (flag8 ? 6'sd0 : 6'sd2);
    end
    disparity_next = new_disparity + delta[tpe_pkg::DISP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      new_disparity <= '0;
    end else begin
      if (advance) begin
        out_valid     <= 1'b1;
        new_disparity <= disparity_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      tmds_symbol <= symbol_next;
      pair_bits   <= tpe_pkg::spread_pairs(symbol_next);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tpe_pkg::positive_bits(pair_bits) == tmds_symbol &&
                   tpe_pkg::negative_bits(pair_bits) == ~tmds_symbol))
    else $error("Differential pair bits disagree with the symbol.");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (hold_valid && out_valid && !out_ready))
    else $error("Input stalled while the pipeline could move.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(new_disparity))
    else $error("Running disparity changed while the output was stalled.");

  assert property (@(posedge clk)
    rst |=> (!out_valid && !hold_valid && new_disparity == '0))
    else $error("Encoder not cleared after reset.");

endmodule
